>>> rtl/etsrch_pkg.sv
// ----------------------------------------------------------------------------
// etsrch_pkg
// Shared types and constants of the edge trigger search block.
// ----------------------------------------------------------------------------
package etsrch_pkg;

    // Fixed field widths of the item, result and configuration port
    localparam int SAMPLE_W    = 12;
    localparam int LEVEL_W     = 12;
    localparam int INDEX_W     = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2048;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_FALLING  = 2'd1;

    // Item modes
    localparam logic MODE_STORE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] trigger_index;
        logic               trigger_found;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store_en;     // write the item's sample at the next ring position
        logic search_load;  // latch the start position, clear the step counter
        logic rd_en;        // read one store entry and shift the sample pair
        logic step;         // move the test position back by one
        logic out_load;     // capture the search result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;   // edge at the current test position
        logic last;  // current test position is the final one of the walk
    } status_t;

endpackage

>>> rtl/scope_edge_trigger_search.sv
// ----------------------------------------------------------------------------
// scope_edge_trigger_search
// Store item: one per cycle while no search is running, no result.
// Search item: two priming reads, then one tested position per cycle, walked
//   back over the single read port of the sample ring; a finished result waits
//   in the test state while an earlier result still waits at the output.
// Reset: asynchronous, active low; no clearing pass, a fill count makes
//   never-written ring entries read as zero, so items are taken at once.
// ----------------------------------------------------------------------------
module scope_edge_trigger_search #(
    parameter int RING_DEPTH   = 2048,
    parameter int SCREEN_WIDTH = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  etsrch_pkg::item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output etsrch_pkg::result_t                 result,
    input  logic                                cfg_wr_en,
    input  logic [etsrch_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [etsrch_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Commands from the sequencer, status back from the datapath.
    // A store transfer writes the ring in the same cycle and keeps the
    // sequencer idle; a search transfer runs two priming reads, then tests
    // one position per cycle, walking backward from the latest position
    // less half the screen. The result register parts the search from the
    // consumer: a finished search holds in the test state until the register
    // is free, while store transfers keep flowing once it returns to idle.
    etsrch_pkg::cmd_t    cmd;
    etsrch_pkg::status_t status;

    etsrch_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_mode    (item.mode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Ring, configuration registers, walk counters, edge compare and result register
    etsrch_dpath #(
        .RING_DEPTH   (RING_DEPTH),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (item.sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

>>> rtl/etsrch_dpath.sv
// ----------------------------------------------------------------------------
// etsrch_dpath
// Sample ring, configuration registers, search address walk, edge compare
// and result register.
// ----------------------------------------------------------------------------
module etsrch_dpath #(
    parameter int RING_DEPTH   = 2048,
    parameter int SCREEN_WIDTH = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  etsrch_pkg::cmd_t                    cmd,
    output etsrch_pkg::status_t                 status,
    input  logic [etsrch_pkg::SAMPLE_W-1:0]     sample,
    input  logic                                cfg_wr_en,
    input  logic [etsrch_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [etsrch_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output etsrch_pkg::result_t                 result
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int STEPS  = RING_DEPTH / 2;
    localparam int CW     = $clog2(STEPS);
    localparam int BACK   = (SCREEN_WIDTH / 2) % RING_DEPTH;
    localparam int LW     = etsrch_pkg::LEVEL_W;
    localparam int IW     = etsrch_pkg::INDEX_W;
    localparam int CMP_W  = (SAMPLE_BITS > LW) ? SAMPLE_BITS : LW;

    localparam logic [AW-1:0] LAST_POS   = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   RING_W     = (AW + 1)'(RING_DEPTH);
    localparam logic [AW:0]   BACK_W     = (AW + 1)'(BACK);
    localparam logic [CW-1:0] LAST_STEP  = CW'(STEPS - 1);

    logic [SAMPLE_BITS-1:0] store_mem [RING_DEPTH];

    logic [AW-1:0]          latest_reg, latest_next;
    logic [AW:0]            fill_reg;
    logic [LW-1:0]          trigger_level_reg;
    logic                   edge_falling_reg;

    logic [AW-1:0]          start_reg;
    logic [AW-1:0]          addr_reg;
    logic [AW-1:0]          pos_reg;
    logic [CW-1:0]          count_reg;

    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_ok_reg;
    logic [SAMPLE_BITS-1:0] samp_old_reg;
    logic [SAMPLE_BITS-1:0] samp_new;

    logic [AW:0]            latest_wide;
    logic [AW:0]            start_wide;
    logic [AW-1:0]          start_pos;
    logic [CMP_W-1:0]       cur_ext, prev_ext, level_ext, sample_ext;
    logic                   cur_above, prev_above;

    // ring arithmetic, works for any depth
    assign latest_next = (latest_reg == LAST_POS) ? '0 : latest_reg + 1'b1;
    assign latest_wide = {1'b0, latest_reg};
    assign start_wide  = (latest_wide >= BACK_W) ? latest_wide - BACK_W
                                                 : latest_wide + RING_W - BACK_W;
    assign start_pos   = start_wide[AW-1:0];

    // entries beyond the fill count were never written and read as zero
    assign samp_new = rd_ok_reg ? rd_data_reg : '0;

    assign sample_ext = CMP_W'(sample);
    assign cur_ext    = CMP_W'(samp_old_reg);
    assign prev_ext   = CMP_W'(samp_new);
    assign level_ext  = CMP_W'(trigger_level_reg);
    assign cur_above  = (cur_ext >= level_ext);
    assign prev_above = (prev_ext >= level_ext);

    assign status.hit  = edge_falling_reg ? (!cur_above && prev_above)
                                          : (cur_above && !prev_above);
    assign status.last = (count_reg == LAST_STEP);

    // control state: ring position, fill count, configuration, step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg        <= LAST_POS;
            fill_reg          <= '0;
            trigger_level_reg <= etsrch_pkg::LEVEL_RESET;
            edge_falling_reg  <= 1'b0;
            count_reg         <= '0;
        end
        else
        begin
            if (cmd.store_en)
            begin
                latest_reg <= latest_next;
                if (fill_reg != RING_W)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    etsrch_pkg::CFG_TRIGGER_LEVEL: trigger_level_reg <= cfg_wdata[LW-1:0];
                    etsrch_pkg::CFG_EDGE_FALLING:  edge_falling_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.search_load)
            begin
                count_reg <= '0;
            end
            else if (cmd.step)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // sample ring write port
    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
        begin
            store_mem[latest_next] <= SAMPLE_BITS'(sample_ext);
        end
    end

    // sample ring read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg  <= store_mem[addr_reg];
            rd_ok_reg    <= ({1'b0, addr_reg} < fill_reg);
            samp_old_reg <= samp_new;
        end
    end

    // walk positions and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.search_load)
        begin
            start_reg <= start_pos;
            addr_reg  <= start_pos;
            pos_reg   <= start_pos;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                addr_reg <= (addr_reg == '0) ? LAST_POS : addr_reg - 1'b1;
            end
            if (cmd.step)
            begin
                pos_reg <= (pos_reg == '0) ? LAST_POS : pos_reg - 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            result.trigger_index <= status.hit ? IW'(pos_reg) : IW'(start_reg);
            result.trigger_found <= status.hit;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= RING_W)
        else $error("fill count exceeds ring depth");

    a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !status.last)
        else $error("walk stepped past its final position");

endmodule

>>> rtl/etsrch_ctrl.sv
// ----------------------------------------------------------------------------
// etsrch_ctrl
// Sequencer for store and search items, and the result valid flag.
// ----------------------------------------------------------------------------
module etsrch_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 item_mode,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  etsrch_pkg::status_t  status,
    output etsrch_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PRIME0 = 4'b0010,
        ST_PRIME1 = 4'b0100,
        ST_SCAN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;
    logic   done;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign done         = status.hit || status.last;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.store_en    = accept && (item_mode == etsrch_pkg::MODE_STORE);
        cmd.search_load = accept && (item_mode == etsrch_pkg::MODE_SEARCH);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.search_load)
                begin
                    state_next = ST_PRIME0;
                end
            end
            ST_PRIME0:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_PRIME1;
            end
            ST_PRIME1:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!done)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.step  = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result captured over an untaken result");

    a_search_primes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_mode == etsrch_pkg::MODE_SEARCH)
            |=> (state_reg == ST_PRIME0))
        else $error("accepted search did not start the read sequence");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (result_valid && item_ready))
        else $error("captured result not presented or block not freed");

endmodule

>>> tb/sv/scope_edge_trigger_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_trigger_search_test
// Self-checking bench for the edge trigger search block. A behavioral copy
// of the sample ring predicts every search result. Directed items cover the
// reset state, register extremes and ignored register indexes. Random
// waveform segments, with stalls on both channels, cover the rest.
// ----------------------------------------------------------------------------
module scope_edge_trigger_search_test;

    localparam int RING_DEPTH   = 2048;
    localparam int SCREEN_WIDTH = 128;
    localparam int SAMPLE_BITS  = 12;

    // Indexes past the register list; writes there must change nothing
    localparam logic [etsrch_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [etsrch_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // Random part: phases, each with its own register setting
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 200;

    // Idle cycles after the last result before a register write; they let a store
    // transfer still in flight complete
    localparam int SETTLE_CYCLES = 8;

    logic                               clk;
    logic                               rst_n;
    logic                               item_valid;
    logic                               item_ready;
    etsrch_pkg::item_t                  item_data;
    logic                               result_valid;
    logic                               result_ready;
    etsrch_pkg::result_t                result_data;
    logic                               cfg_wr_en;
    logic [etsrch_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [etsrch_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Shadow copy of the block state
    logic [etsrch_pkg::SAMPLE_W-1:0] sample_ring [RING_DEPTH];
    logic [etsrch_pkg::INDEX_W-1:0]  ring_head;
    logic [etsrch_pkg::LEVEL_W-1:0]  cfg_level;
    logic                            cfg_falling;

    // Search results still owed by the block, oldest first
    etsrch_pkg::result_t trigger_queue [$];

    int  mismatches  = 0;
    bit  tail_quiet  = 1'b0;

    scope_edge_trigger_search #(
        .RING_DEPTH   (RING_DEPTH),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop; far beyond the slowest legal run (every item a full-length
    // search with the longest stalls on both sides), given in ns
    initial
    begin
        #200_000_000;
        $display("scope_edge_trigger_search_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    task automatic reset_shadow();
        for (int i = 0; i < RING_DEPTH; i++)
            sample_ring[i] = '0;
        ring_head   = etsrch_pkg::INDEX_W'(RING_DEPTH - 1);
        cfg_level   = etsrch_pkg::LEVEL_RESET;
        cfg_falling = 1'b0;
    endtask

    // True when the samples at pos-1 and pos straddle the level in the
    // configured direction
    function automatic bit crosses_level(input logic [etsrch_pkg::INDEX_W-1:0] pos);
        logic [etsrch_pkg::INDEX_W-1:0]  prev_pos;
        logic [etsrch_pkg::SAMPLE_W-1:0] cur;
        logic [etsrch_pkg::SAMPLE_W-1:0] prev;
        prev_pos = pos - 1'b1;
        cur      = sample_ring[pos];
        prev     = sample_ring[prev_pos];
        if (cfg_falling)
            return (cur < cfg_level) && (prev >= cfg_level);
        return (cur >= cfg_level) && (prev < cfg_level);
    endfunction

    // Walk back half the ring from half a screen behind the newest sample;
    // the ring depth is a power of two, so index arithmetic wraps by itself
    function automatic etsrch_pkg::result_t predict_trigger();
        logic [etsrch_pkg::INDEX_W-1:0] start;
        logic [etsrch_pkg::INDEX_W-1:0] pos;
        etsrch_pkg::result_t            res;
        start             = ring_head - etsrch_pkg::INDEX_W'(SCREEN_WIDTH / 2);
        pos               = start;
        res.trigger_index = start;
        res.trigger_found = 1'b0;
        for (int n = 0; n < RING_DEPTH / 2; n++)
        begin
            if (crosses_level(pos))
            begin
                res.trigger_index = pos;
                res.trigger_found = 1'b1;
                return res;
            end
            pos = pos - 1'b1;
        end
        return res;
    endfunction

    // Advance the shadow on an accepted transfer
    task automatic apply_item(input etsrch_pkg::item_t it);
        if (it.mode == etsrch_pkg::MODE_STORE)
        begin
            ring_head              = ring_head + 1'b1;
            sample_ring[ring_head] = it.sample;
        end
        else
            trigger_queue.push_back(predict_trigger());
    endtask

    // Pick a sample on the requested side of the current level; with the
    // level at zero nothing lies below, so any value will do
    function automatic logic [etsrch_pkg::SAMPLE_W-1:0] pick_sample(input bit above);
        if (above)
            return etsrch_pkg::SAMPLE_W'($urandom_range(4095, cfg_level));
        if (cfg_level == '0)
            return etsrch_pkg::SAMPLE_W'($urandom_range(4095, 0));
        return etsrch_pkg::SAMPLE_W'($urandom_range(cfg_level - 1'b1, 0));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one item and hold it until the transfer; valid stays high on
    // return so a following item can go out back to back
    task automatic send_item(input etsrch_pkg::item_t it);
        item_valid <= 1'b1;
        item_data  <= it;
        do
            @(posedge clk);
        while (!item_ready);
        apply_item(it);
    endtask

    // Drop valid for a burst of idle cycles
    task automatic hold_off(input int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending, wait for every owed result, then let a store in
    // flight finish so the block is idle
    task automatic drain_results();
        item_valid <= 1'b0;
        while (trigger_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the enable is low again when the task returns
    task automatic write_reg(input logic [etsrch_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [etsrch_pkg::CFG_DATA_W-1:0]  data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            etsrch_pkg::CFG_TRIGGER_LEVEL: cfg_level   = data;
            etsrch_pkg::CFG_EDGE_FALLING:  cfg_falling = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------------

    // Stall windows are switched on or off at random so that some stretches
    // run with ready held high; none once the quiet tail starts
    initial
    begin
        int cycles;
        bit stall_window;
        cycles       = 0;
        stall_window = 1'b1;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!tail_quiet && stall_window && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            cycles++;
            if (cycles % 256 == 0)
                stall_window = ($urandom_range(0, 2) != 0);
        end
    end

    // Compare each result transfer with the oldest owed result
    initial
    begin
        etsrch_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (trigger_queue.size() == 0)
                    report_mismatch($sformatf("result with none owed: index %0d found %0d",
                                              result_data.trigger_index,
                                              result_data.trigger_found));
                else
                begin
                    want = trigger_queue.pop_front();
                    if (result_data.trigger_index !== want.trigger_index)
                        report_mismatch($sformatf("trigger_index got %0d expected %0d",
                                                  result_data.trigger_index,
                                                  want.trigger_index));
                    if (result_data.trigger_found !== want.trigger_found)
                        report_mismatch($sformatf("trigger_found got %0d expected %0d",
                                                  result_data.trigger_found,
                                                  want.trigger_found));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Search the all-zero ring straight out of reset, rising then falling;
    // neither can find an edge, so both fall back to the start position
    task automatic test_reset_state();
        etsrch_pkg::item_t it;
        it.mode   = etsrch_pkg::MODE_SEARCH;
        it.sample = '1;
        send_item(it);
        drain_results();
        // Upper data bits set: only bit zero selects the direction
        write_reg(etsrch_pkg::CFG_EDGE_FALLING, 12'hFFF);
        it.sample = '0;
        send_item(it);
        drain_results();
    endtask

    // Writes past the register list must leave level and direction alone
    task automatic test_ignored_writes();
        etsrch_pkg::item_t it;
        write_reg(CFG_SPARE_A, 12'hFFF);
        write_reg(CFG_SPARE_B, etsrch_pkg::CFG_DATA_W'($urandom_range(0, 4095)));
        it.mode   = etsrch_pkg::MODE_STORE;
        it.sample = 12'hFFF;
        send_item(it);
        it.sample = 12'h000;
        send_item(it);
        it.mode   = etsrch_pkg::MODE_SEARCH;
        it.sample = etsrch_pkg::CFG_DATA_W'($urandom_range(0, 4095));
        send_item(it);
        drain_results();
    endtask

    // Level at both ends of its range, both directions, extreme samples
    task automatic test_field_extremes();
        etsrch_pkg::item_t it;
        write_reg(etsrch_pkg::CFG_TRIGGER_LEVEL, 12'd4095);
        write_reg(etsrch_pkg::CFG_EDGE_FALLING, 12'hFFE);
        it.mode = etsrch_pkg::MODE_STORE;
        it.sample = 12'h000;  send_item(it);
        it.sample = 12'hFFF;  send_item(it);
        it.sample = 12'hFFF;  send_item(it);
        it.sample = 12'h000;  send_item(it);
        it.sample = 12'hAAA;  send_item(it);
        it.sample = 12'h555;  send_item(it);
        it.mode   = etsrch_pkg::MODE_SEARCH;
        it.sample = 12'hFFF;
        send_item(it);
        drain_results();
        write_reg(etsrch_pkg::CFG_EDGE_FALLING, 12'h001);
        it.sample = 12'h000;
        send_item(it);
        drain_results();
        // A zero level can never be crossed in either direction
        write_reg(etsrch_pkg::CFG_TRIGGER_LEVEL, 12'd0);
        send_item(it);
        drain_results();
        write_reg(etsrch_pkg::CFG_TRIGGER_LEVEL, 12'd1);
        write_reg(etsrch_pkg::CFG_EDGE_FALLING, 12'h000);
        send_item(it);
        drain_results();
    endtask

    // Waveforms built from runs on one side of the level, with some noise
    // runs and lone glitches; searches land at random among the stores
    task automatic test_random_waveforms();
        etsrch_pkg::item_t                 it;
        logic [etsrch_pkg::LEVEL_W-1:0]    lvl;
        logic [etsrch_pkg::CFG_DATA_W-1:0] dir_word;
        int                                sent;
        int                                seg_len;
        int                                pick;
        bit                                above;
        bit                                noisy;
        bit                                gaps_on;
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       lvl = 12'd0;
                1:       lvl = 12'd4095;
                2:       lvl = 12'd1;
                N_PHASES - 1: lvl = 12'd4094;
                default: lvl = etsrch_pkg::LEVEL_W'($urandom_range(0, 4095));
            endcase
            dir_word    = etsrch_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            dir_word[0] = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
            write_reg(etsrch_pkg::CFG_TRIGGER_LEVEL, lvl);
            write_reg(etsrch_pkg::CFG_EDGE_FALLING, dir_word);

            // The last phase runs with no idling on either side
            tail_quiet = (p == N_PHASES - 1);
            gaps_on    = !tail_quiet && ($urandom_range(0, 3) != 0);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                noisy = ($urandom_range(0, 9) == 0);
                above = 1'($urandom_range(0, 1));
                pick  = $urandom_range(0, 19);
                if (pick < 15)
                    seg_len = $urandom_range(1, 32);
                else if (pick < 19)
                    seg_len = $urandom_range(33, 160);
                else
                    seg_len = $urandom_range(161, 600);

                for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++)
                begin
                    if (gaps_on && $urandom_range(0, 7) == 0)
                        hold_off($urandom_range(1, 14));
                    if ($urandom_range(0, 24) == 0)
                    begin
                        it.mode   = etsrch_pkg::MODE_SEARCH;
                        it.sample = etsrch_pkg::SAMPLE_W'($urandom_range(0, 4095));
                        send_item(it);
                        sent++;
                        // Now and then hold the sender until the result is in
                        if (!tail_quiet && $urandom_range(0, 3) == 0)
                            drain_results();
                    end
                    it.mode = etsrch_pkg::MODE_STORE;
                    if (noisy)
                        it.sample = etsrch_pkg::SAMPLE_W'($urandom_range(0, 4095));
                    else if ($urandom_range(0, 39) == 0)
                        it.sample = pick_sample(!above);
                    else
                        it.sample = pick_sample(above);
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item_data  <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        reset_shadow();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_ignored_writes();
        test_field_extremes();
        test_random_waveforms();

        // Wait out the longest search so a stray result still shows up
        drain_results();
        repeat (RING_DEPTH / 2 + 8) @(posedge clk);
        if (trigger_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", trigger_queue.size()));

        if (mismatches == 0)
            $display("scope_edge_trigger_search_test OK");
        else
            $display("scope_edge_trigger_search_test NOT OK");
        $finish;
    end

endmodule
